// ----- rtl/led_matrix_column_scanner_core_macros.svh -----
// ----------------------------------------------------------------------------
// LED matrix column scanner assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_COLUMN_SCANNER_CORE_MACROS_SVH
`define LED_MATRIX_COLUMN_SCANNER_CORE_MACROS_SVH

// Same-cycle implication.
`define LMCS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LMCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lmcs_pkg.sv -----
// ----------------------------------------------------------------------------
// LED matrix column scanner package
// Opcodes and the command record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package lmcs_pkg;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET       = 3'd1,
    OP_LOAD      = 3'd2,
    OP_CLR_PLANE = 3'd3,
    OP_CLR_BOTH  = 3'd4
  } opcode_t;

  localparam int unsigned MaskWidth = 64;
  localparam int unsigned RowBits   = 8;

  typedef struct packed {
    opcode_t                op;
    logic                   color;
    logic [2:0]             row;
    logic [2:0]             column;
    logic                   value;
    logic [MaskWidth-1:0]   plane_mask;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ----- rtl/lmcs_if.sv -----
// ----------------------------------------------------------------------------
// LED matrix column scanner channels
// Valid/ready interfaces for the command input and the column result output.
// ----------------------------------------------------------------------------
interface lmcs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic        color;
  logic [2:0]  row;
  logic [2:0]  column;
  logic        value;
  logic [63:0] plane_mask;

  modport source (output valid, opcode, color, row, column, value, plane_mask,
                  input ready);
  modport sink (input valid, opcode, color, row, column, value, plane_mask,
                output ready);
endinterface

interface lmcs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] active_column;
  logic       column_enable;
  logic [7:0] red_rows;
  logic [7:0] blue_rows;

  modport source (output valid, active_column, column_enable, red_rows, blue_rows,
                  input ready);
  modport sink (input valid, active_column, column_enable, red_rows, blue_rows,
                output ready);
endinterface

// ----- rtl/lmcs_front.sv -----
// ----------------------------------------------------------------------------
// LED matrix column scanner front end
// Accepts input items, drops unused opcodes and off-grid squares, queues the rest.
// ----------------------------------------------------------------------------
module lmcs_front #(
  parameter int unsigned GRID_SIZE = 8
) (
  lmcs_in_if.sink              item,
  input  lmcs_pkg::queue_status_t q_stat,
  output logic                 push,
  output lmcs_pkg::cmd_t       cmd
);

  logic keep;
  logic in_grid;

  assign in_grid = (32'(item.row) < GRID_SIZE) && (32'(item.column) < GRID_SIZE);

  always_comb begin
    unique case (item.opcode)
      lmcs_pkg::OP_TICK, lmcs_pkg::OP_LOAD,
      lmcs_pkg::OP_CLR_PLANE, lmcs_pkg::OP_CLR_BOTH: keep = 1'b1;
      lmcs_pkg::OP_SET: keep = in_grid;
      default: keep = 1'b0;
    endcase
  end

  assign item.ready = !q_stat.full;
  assign push       = item.valid && !q_stat.full && keep;

  assign cmd.op         = lmcs_pkg::opcode_t'(item.opcode);
  assign cmd.color      = item.color;
  assign cmd.row        = item.row;
  assign cmd.column     = item.column;
  assign cmd.value      = item.value;
  assign cmd.plane_mask = item.plane_mask;

endmodule

// ----- rtl/lmcs_queue.sv -----
// ----------------------------------------------------------------------------
// LED matrix column scanner command queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module lmcs_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  lmcs_pkg::cmd_t          push_data,
  input  logic                    pop,
  output lmcs_pkg::cmd_t          pop_data,
  output lmcs_pkg::queue_status_t q_stat
);

  lmcs_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign q_stat.empty = (count == 2'd0);
  assign q_stat.full  = (count == 2'd2);
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/lmcs_back.sv -----
// ----------------------------------------------------------------------------
// LED matrix column scanner back end
// Holds both frames and the scan pointer, runs commands, searches one column
// per cycle on a tick and registers the column result.
// ----------------------------------------------------------------------------
module lmcs_back #(
  parameter int unsigned GRID_SIZE = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lmcs_pkg::queue_status_t q_stat,
  input  lmcs_pkg::cmd_t          cmd,
  output logic                    pop,
  lmcs_out_if.source              result
);

  localparam int unsigned CW = $clog2(GRID_SIZE);
  localparam int unsigned RN = (GRID_SIZE < 8) ? GRID_SIZE : 8;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_EMIT} state_t;

  state_t                 state;
  logic [GRID_SIZE-1:0]   red_frame  [GRID_SIZE];
  logic [GRID_SIZE-1:0]   blue_frame [GRID_SIZE];
  logic [CW-1:0]          scan;
  logic [CW-1:0]          scan_next;
  logic [GRID_SIZE-1:0]   red_col;
  logic [GRID_SIZE-1:0]   blue_col;
  logic [GRID_SIZE+7:0]   red_ext;
  logic [GRID_SIZE+7:0]   blue_ext;
  logic [CW+2:0]          scan_ext;
  logic                   col_lit;
  logic                   at_last;
  logic                   out_valid;
  logic [2:0]             out_column;
  logic                   out_enable;
  logic [7:0]             out_red;
  logic [7:0]             out_blue;

  always_comb begin
    for (int r = 0; r < GRID_SIZE; r++) begin
      red_col[r]  = red_frame[r][scan];
      blue_col[r] = blue_frame[r][scan];
    end
  end

  assign col_lit   = |(red_col | blue_col);
  assign at_last   = (scan == CW'(GRID_SIZE - 1));
  assign scan_next = at_last ? '0 : scan + CW'(1);
  assign red_ext   = (GRID_SIZE + 8)'(red_col);
  assign blue_ext  = (GRID_SIZE + 8)'(blue_col);
  assign scan_ext  = (CW + 3)'(scan);

  assign pop = (state == S_IDLE) && !q_stat.empty;

  assign result.valid         = out_valid;
  assign result.active_column = out_column;
  assign result.column_enable = out_enable;
  assign result.red_rows      = out_red;
  assign result.blue_rows     = out_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan      <= '0;
      out_valid <= 1'b0;
      for (int r = 0; r < GRID_SIZE; r++) begin
        red_frame[r]  <= '0;
        blue_frame[r] <= '0;
      end
    end else begin
      // the emit state reloads the output register itself
      if (result.valid && result.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            case (cmd.op)
              lmcs_pkg::OP_TICK: begin
                scan  <= scan_next;
                state <= S_SEARCH;
              end
              lmcs_pkg::OP_SET: begin
                for (int r = 0; r < GRID_SIZE; r++) begin
                  for (int c = 0; c < GRID_SIZE; c++) begin
                    if (32'(cmd.row) == r && 32'(cmd.column) == c) begin
                      if (cmd.color) begin
                        blue_frame[r][c] <= cmd.value;
                      end else begin
                        red_frame[r][c] <= cmd.value;
                      end
                    end
                  end
                end
              end
              lmcs_pkg::OP_LOAD: begin
                for (int r = 0; r < RN; r++) begin
                  for (int c = 0; c < RN; c++) begin
                    if (cmd.color) begin
                      blue_frame[r][c] <= cmd.plane_mask[r*8+c];
                    end else begin
                      red_frame[r][c] <= cmd.plane_mask[r*8+c];
                    end
                  end
                end
              end
              lmcs_pkg::OP_CLR_PLANE: begin
                for (int r = 0; r < GRID_SIZE; r++) begin
                  if (cmd.color) begin
                    blue_frame[r] <= '0;
                  end else begin
                    red_frame[r] <= '0;
                  end
                end
              end
              lmcs_pkg::OP_CLR_BOTH: begin
                for (int r = 0; r < GRID_SIZE; r++) begin
                  red_frame[r]  <= '0;
                  blue_frame[r] <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SEARCH: begin
          // stop on a lit column or at the last column, else advance
          if (col_lit || at_last) begin
            state <= S_EMIT;
          end else begin
            scan <= scan_next;
          end
        end
        S_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_column <= scan_ext[2:0];
            out_enable <= col_lit;
            out_red    <= red_ext[7:0];
            out_blue   <= blue_ext[7:0];
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/led_matrix_column_scanner_core.sv -----
// ----------------------------------------------------------------------------
// LED matrix column scanner core
// Two-colour column-multiplexed LED matrix driver with a decoupled command
// front end and a frame/scan back end.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready command channel. Opcodes tick, set square, load plane,
//            clear plane and clear both. Unused opcodes and squares off the
//            grid are dropped on acceptance with no result.
//   result : valid/ready channel, one transaction per tick carrying the
//            active column, its enable and its red and blue row bits.
//   A two-entry queue sits between the front end and the back end, so items
//   keep being accepted while the back end works or the result waits.
//   Write commands are run in the back end's idle state. A tick is issued from
//   the idle state, then the search examines one column per cycle (1 to
//   GRID_SIZE columns) and the emit state loads the output register. The
//   back end takes no new command until that result is loaded, so the
//   one-column-per-cycle search and a stalled receiver set the tick rate.
//   Reset clears both frames, sets the scan column to 0 and empties the queue.
//   A stalled receiver holds the result; the back end waits at the output
//   register and the queue fills, after which item.ready drops.
// ----------------------------------------------------------------------------
`include "led_matrix_column_scanner_core_macros.svh"

module led_matrix_column_scanner_core #(
  parameter int unsigned GRID_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst,
  lmcs_in_if.sink     item,
  lmcs_out_if.source  result
);

  lmcs_pkg::queue_status_t q_stat;
  lmcs_pkg::cmd_t          push_cmd;
  lmcs_pkg::cmd_t          pop_cmd;
  logic                    push;
  logic                    pop;

  lmcs_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .item   (item),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (push_cmd)
  );

  lmcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .q_stat    (q_stat)
  );

  lmcs_back #(.GRID_SIZE(GRID_SIZE)) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .cmd    (pop_cmd),
    .pop    (pop),
    .result (result)
  );

  `LMCS_ASSERT_IMPL(a_no_overflow, push, !q_stat.full, "push into full queue")
  `LMCS_ASSERT_IMPL(a_no_underflow, pop, !q_stat.empty, "pop from empty queue")
  `LMCS_ASSERT_IMPL(a_dark_rows, result.valid && !result.column_enable,
    result.red_rows == 8'd0 && result.blue_rows == 8'd0, "dark column shows rows")
  `LMCS_ASSERT_IMPL(a_dark_last, result.valid && !result.column_enable,
    result.active_column == 3'(GRID_SIZE - 1), "dark column is not the last")

endmodule

// ----- test/lmcs_scan_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix column scanner checker
// Watches the command and result channels and keeps its own copy of both
// frames and the scan column. Each accepted tick queues the column view that
// the scanner should report. Each accepted result is compared, field by
// field, with the oldest queued view.
// ----------------------------------------------------------------------------
module lmcs_scan_checker #(
  parameter int unsigned GRID_SIZE = 8
) (
  input  logic clk,
  input  logic rst,
  lmcs_in_if   item,
  lmcs_out_if  result,
  output int   fail_count,
  output int   pending_ticks
);

  typedef struct packed {
    logic [2:0] column;
    logic       enable;
    logic [7:0] red;
    logic [7:0] blue;
  } column_view_t;

  // Column-major copy of the frames: entry c, bit r is square (r, c).
  logic [7:0]   red_cols  [GRID_SIZE];
  logic [7:0]   blue_cols [GRID_SIZE];
  int unsigned  scan_col;
  column_view_t views_due [$];
  int           mismatches = 0;
  int           outstanding = 0;

  assign fail_count    = mismatches;
  assign pending_ticks = outstanding;

  // Step at least once, then stop on the first lit column or the last one.
  function automatic column_view_t advance_scan();
    column_view_t view;
    logic         lit;
    do begin
      scan_col = (scan_col + 1) % GRID_SIZE;
      lit      = (red_cols[scan_col] | blue_cols[scan_col]) != '0;
    end while (!lit && scan_col != GRID_SIZE - 1);
    view.column = scan_col[2:0];
    view.enable = lit;
    view.red    = red_cols[scan_col];
    view.blue   = blue_cols[scan_col];
    return view;
  endfunction

  always @(posedge clk) begin
    column_view_t want;
    logic [2:0]   op;
    if (rst) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        red_cols[c]  = '0;
        blue_cols[c] = '0;
      end
      scan_col = 0;
      views_due.delete();
    end else begin
      // Retire the result first: a tick accepted on this edge cannot be it.
      if (result.valid && result.ready) begin
        if (views_due.size() == 0) begin
          $error("result transaction with no tick outstanding: column %0d",
                 result.active_column);
          mismatches++;
        end else begin
          want = views_due.pop_front();
          if (result.active_column !== want.column) begin
            $error("active_column mismatch: expected %0d, actual %0d",
                   want.column, result.active_column);
            mismatches++;
          end
          if (result.column_enable !== want.enable) begin
            $error("column_enable mismatch: expected %0b, actual %0b",
                   want.enable, result.column_enable);
            mismatches++;
          end
          if (result.red_rows !== want.red) begin
            $error("red_rows mismatch: expected %02h, actual %02h",
                   want.red, result.red_rows);
            mismatches++;
          end
          if (result.blue_rows !== want.blue) begin
            $error("blue_rows mismatch: expected %02h, actual %02h",
                   want.blue, result.blue_rows);
            mismatches++;
          end
        end
      end

      if (item.valid && item.ready) begin
        op = item.opcode;
        case (op)
          lmcs_pkg::OP_TICK: views_due.push_back(advance_scan());
          lmcs_pkg::OP_SET: begin
            // Drop squares off the grid.
            if (item.row < GRID_SIZE && item.column < GRID_SIZE) begin
              if (item.color)
                blue_cols[item.column][item.row] = item.value;
              else
                red_cols[item.column][item.row] = item.value;
            end
          end
          lmcs_pkg::OP_LOAD: begin
            for (int r = 0; r < 8; r++) begin
              for (int c = 0; c < 8; c++) begin
                if (r < GRID_SIZE && c < GRID_SIZE) begin
                  if (item.color)
                    blue_cols[c][r] = item.plane_mask[r*8 + c];
                  else
                    red_cols[c][r] = item.plane_mask[r*8 + c];
                end
              end
            end
          end
          lmcs_pkg::OP_CLR_PLANE: begin
            for (int c = 0; c < GRID_SIZE; c++) begin
              if (item.color)
                blue_cols[c] = '0;
              else
                red_cols[c] = '0;
            end
          end
          lmcs_pkg::OP_CLR_BOTH: begin
            for (int c = 0; c < GRID_SIZE; c++) begin
              red_cols[c]  = '0;
              blue_cols[c] = '0;
            end
          end
          default: ; // unused opcodes leave everything as it is
        endcase
      end
    end
    outstanding = views_due.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix column scanner testbench
// Drives a directed command sequence and then a long random one through the
// scanner, with random gaps on the command side and random stalls on the
// result side. The checker beside the block predicts and compares; this
// module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned GRID_SIZE       = 8;
  localparam logic        RED             = 1'b0;
  localparam logic        BLUE            = 1'b1;
  localparam logic [2:0]  OP_TICK         = lmcs_pkg::OP_TICK;
  localparam logic [2:0]  OP_SET          = lmcs_pkg::OP_SET;
  localparam logic [2:0]  OP_LOAD         = lmcs_pkg::OP_LOAD;
  localparam logic [2:0]  OP_CLR_PLANE    = lmcs_pkg::OP_CLR_PLANE;
  localparam logic [2:0]  OP_CLR_BOTH     = lmcs_pkg::OP_CLR_BOTH;
  localparam logic [2:0]  OP_UNUSED_FIRST = OP_CLR_BOTH + 3'd1;
  localparam logic [2:0]  OP_UNUSED_LAST  = 3'd7;
  localparam logic [63:0] ONE_COLUMN      = 64'h0101_0101_0101_0101;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic gaps_on = 1'b1;
  int   fail_count;
  int   pending_ticks;

  lmcs_in_if  cmd_ch ();
  lmcs_out_if col_ch ();

  led_matrix_column_scanner_core #(.GRID_SIZE(GRID_SIZE)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (cmd_ch),
    .result (col_ch)
  );

  lmcs_scan_checker #(.GRID_SIZE(GRID_SIZE)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .item          (cmd_ch),
    .result        (col_ch),
    .fail_count    (fail_count),
    .pending_ticks (pending_ticks)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: stall at random, except while gaps are off.
  initial begin
    col_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      col_ch.ready <= !(gaps_on && $urandom_range(99) < 12);
    end
  end

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_cmd(input logic [2:0] op, input logic color, input logic [2:0] row,
                          input logic [2:0] column, input logic value,
                          input logic [63:0] mask);
    while (gaps_on && $urandom_range(99) < 12) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.opcode     <= op;
    cmd_ch.color      <= color;
    cmd_ch.row        <= row;
    cmd_ch.column     <= column;
    cmd_ch.value      <= value;
    cmd_ch.plane_mask <= mask;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    logic [2:0]  op;
    logic [63:0] mask;
    int          pick;

    cmd_ch.valid      = 1'b0;
    cmd_ch.opcode     = OP_TICK;
    cmd_ch.color      = RED;
    cmd_ch.row        = '0;
    cmd_ch.column     = '0;
    cmd_ch.value      = 1'b0;
    cmd_ch.plane_mask = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty frames: the search runs out at the last column, twice.
    send_cmd(OP_TICK, RED, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_TICK, BLUE, 3'd7, 3'd7, 1'b1, '1);
    send_cmd(OP_SET, RED, 3'd0, 3'd0, 1'b1, '0);
    send_cmd(OP_TICK, RED, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_SET, BLUE, 3'd7, 3'd7, 1'b1, '1);
    send_cmd(OP_SET, RED, 3'd7, 3'd3, 1'b1, '0);
    send_cmd(OP_TICK, RED, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_TICK, RED, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_SET, BLUE, 3'd7, 3'd7, 1'b0, '0);
    send_cmd(OP_TICK, RED, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_LOAD, RED, 3'd5, 3'd2, 1'b1, '1);
    send_cmd(OP_LOAD, BLUE, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_TICK, RED, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_LOAD, BLUE, 3'd0, 3'd0, 1'b0, 64'hAAAA_5555_AAAA_5555);
    send_cmd(OP_CLR_PLANE, RED, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_TICK, RED, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_CLR_PLANE, BLUE, 3'd0, 3'd0, 1'b0, '1);
    send_cmd(OP_TICK, RED, 3'd0, 3'd0, 1'b0, '0);
    // Unused opcodes must leave the frames alone.
    send_cmd(OP_LOAD, RED, 3'd0, 3'd0, 1'b0, 64'h8000_0000_0000_0001);
    send_cmd(OP_UNUSED_FIRST, RED, 3'd0, 3'd0, 1'b1, '1);
    send_cmd(OP_UNUSED_FIRST + 3'd1, BLUE, 3'd7, 3'd7, 1'b1, '1);
    send_cmd(OP_UNUSED_LAST, BLUE, 3'd3, 3'd4, 1'b0, '0);
    send_cmd(OP_TICK, RED, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_CLR_BOTH, BLUE, 3'd0, 3'd0, 1'b0, '0);
    send_cmd(OP_TICK, RED, 3'd0, 3'd0, 1'b0, '0);

    for (int i = 0; i < 600; i++) begin
      gaps_on <= !(i >= 250 && i < 380);
      mask = {$urandom, $urandom};
      case ($urandom_range(4))
        0: ;
        1: mask = mask & {$urandom, $urandom} & {$urandom, $urandom};
        2: mask = mask & (ONE_COLUMN << $urandom_range(7));
        3: mask = '0;
        default: mask = '1;
      endcase
      pick = $urandom_range(99);
      if (pick < 40)
        op = OP_TICK;
      else if (pick < 70)
        op = OP_SET;
      else if (pick < 78)
        op = OP_LOAD;
      else if (pick < 84)
        op = OP_CLR_PLANE;
      else if (pick < 88)
        op = OP_CLR_BOTH;
      else if (pick < 92)
        op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      else
        op = OP_TICK;
      send_cmd(op, 1'($urandom_range(1)), 3'($urandom_range(7)), 3'($urandom_range(7)),
               $urandom_range(9) < 7, mask);
    end
    cmd_ch.valid <= 1'b0;
    gaps_on      <= 1'b1;

    while (pending_ticks != 0) @(negedge clk);
    // Hold a little longer to catch any stray result.
    repeat (GRID_SIZE + 8) @(negedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
